// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication shorthand on the same clocking.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/cbts_pkg.sv =====
package cbts_pkg;

    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int MAX_GROUPS_DEF   = 8;
    localparam int MAX_SELECT_DEF   = 64;

    localparam int VALUE_W    = 32;
    localparam int LABEL_W    = 4;
    localparam int WEIGHT_W   = 17;
    localparam int INDEX_W    = 12;
    localparam int TOTAL_W    = 13;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 7;
    localparam int GROUP_W    = 3;
    localparam int SPARSITY_W = 7;
    localparam int GCOUNT_W   = 4;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam int REM_W  = 10;
    localparam int BUD_W  = 14;
    localparam int PROD_W = WEIGHT_W + 1 + REM_W;
    localparam int K_W    = 8;
    localparam int Q_SHIFT = 16;

    localparam logic [SPARSITY_W-1:0] SPARSITY_RST = 7'd10;
    localparam logic [GCOUNT_W-1:0]   GCOUNT_RST   = 4'd1;
    localparam logic [WEIGHT_W-1:0]   THRESH_RST   = 17'd6554;

    typedef enum logic [1:0] {
        OP_LOAD_ELEM   = 2'd0,
        OP_LOAD_WEIGHT = 2'd1,
        OP_RUN         = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_SPARSITY = 2'd0,
        REG_GCOUNT   = 2'd1,
        REG_THRESH   = 2'd2,
        REG_DOUBLE   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_REM,
        ST_GROUP,
        ST_BMUL,
        ST_BSET,
        ST_PICK,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic start_run;
        logic count_step;
        logic rem_calc;
        logic bud_mul;
        logic bud_set;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic next_group;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic count_end;
        logic group_end;
        logic pick_more;
        logic scan_done;
        logic pick_ok;
        logic commit_free;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/cbts_ram.sv =====
module cbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/cbts_ctrl.sv =====
module cbts_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_operation,
    output logic                s_ready,
    input  cbts_pkg::status_t   sts,
    output cbts_pkg::cmd_t      cmd
);

    cbts_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            cbts_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_operation == cbts_pkg::OP_RUN) begin
                    cmd.start_run = 1'b1;
                    state_next    = cbts_pkg::ST_COUNT;
                end
            end
            cbts_pkg::ST_COUNT: begin
                if (sts.count_end) begin
                    state_next = cbts_pkg::ST_REM;
                end else begin
                    cmd.count_step = 1'b1;
                end
            end
            cbts_pkg::ST_REM: begin
                cmd.rem_calc = 1'b1;
                state_next   = cbts_pkg::ST_GROUP;
            end
            cbts_pkg::ST_GROUP: begin
                if (sts.group_end) begin
                    state_next = cbts_pkg::ST_FLUSH;
                end else begin
                    state_next = cbts_pkg::ST_BMUL;
                end
            end
            cbts_pkg::ST_BMUL: begin
                cmd.bud_mul = 1'b1;
                state_next  = cbts_pkg::ST_BSET;
            end
            cbts_pkg::ST_BSET: begin
                cmd.bud_set = 1'b1;
                state_next  = cbts_pkg::ST_PICK;
            end
            cbts_pkg::ST_PICK: begin
                if (sts.pick_more) begin
                    cmd.scan_start = 1'b1;
                    state_next     = cbts_pkg::ST_SCAN;
                end else begin
                    cmd.next_group = 1'b1;
                    state_next     = cbts_pkg::ST_GROUP;
                end
            end
            cbts_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = cbts_pkg::ST_DECIDE;
                end
            end
            cbts_pkg::ST_DECIDE: begin
                if (!sts.pick_ok) begin
                    cmd.next_group = 1'b1;
                    state_next     = cbts_pkg::ST_GROUP;
                end else if (sts.commit_free) begin
                    cmd.commit = 1'b1;
                    state_next = cbts_pkg::ST_PICK;
                end
            end
            cbts_pkg::ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = cbts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/cbts_datapath.sv =====
module cbts_datapath #(
    parameter int MAX_ELEMENTS = cbts_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_GROUPS   = cbts_pkg::MAX_GROUPS_DEF,
    parameter int MAX_SELECT   = cbts_pkg::MAX_SELECT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cbts_pkg::cmd_t                      cmd,
    output cbts_pkg::status_t                   sts,
    input  logic                                load_en,
    input  logic [1:0]                          s_operation,
    input  logic [cbts_pkg::INDEX_W-1:0]        s_element_index,
    input  logic signed [cbts_pkg::VALUE_W-1:0] s_element_value,
    input  logic [cbts_pkg::LABEL_W-1:0]        s_element_label,
    input  logic [cbts_pkg::SLOT_W-1:0]         s_group_slot,
    input  logic [cbts_pkg::WEIGHT_W-1:0]       s_group_weight,
    input  logic [cbts_pkg::TOTAL_W-1:0]        s_element_total,
    input  logic [cbts_pkg::SPARSITY_W-1:0]     cfg_sparsity,
    input  logic [cbts_pkg::GCOUNT_W-1:0]       cfg_gcount,
    input  logic [cbts_pkg::WEIGHT_W-1:0]       cfg_thresh,
    input  logic                                cfg_double,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cbts_pkg::INDEX_W-1:0]        m_chosen_index,
    output logic [cbts_pkg::GROUP_W-1:0]        m_chosen_group,
    output logic [cbts_pkg::COUNT_W-1:0]        m_chosen_count,
    output logic                                m_nothing_chosen,
    output logic                                m_last_result
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam int GI = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int VW = cbts_pkg::VALUE_W;
    localparam int LW = cbts_pkg::LABEL_W;
    localparam int WW = cbts_pkg::WEIGHT_W;
    localparam int RW = cbts_pkg::REM_W;
    localparam int BW = cbts_pkg::BUD_W;
    localparam int PW = cbts_pkg::PROD_W;
    localparam int KW = cbts_pkg::K_W;
    localparam int NW = cbts_pkg::COUNT_W;

    // element store: label on top, value below
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [LW+VW-1:0] ram_wdata, ram_rdata;

    cbts_ram #(.WIDTH(LW + VW), .DEPTH(MAX_ELEMENTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [WW-1:0] weight_reg [MAX_GROUPS];

    logic [CW-1:0]          sz_reg, sz_next;
    logic [GW-1:0]          gc_reg, gc_next;
    logic [cbts_pkg::SPARSITY_W-1:0] level_reg, level_next;
    logic                   dbl_reg, dbl_next;
    logic [WW-1:0]          thr_reg, thr_next;
    logic [GW-1:0]          g_reg, g_next;
    logic [GW-1:0]          ncc_reg, ncc_next, nct_reg, nct_next;
    logic signed [RW-1:0]   rem_reg, rem_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [BW-1:0]   bud_reg, bud_next, used_reg, used_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [CW-1:0]          addr_reg, addr_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [AW-1:0]          rd_idx_reg, rd_idx_next;
    logic                   found_reg, found_next;
    logic signed [VW-1:0]   best_v_reg, best_v_next, prev_v_reg, prev_v_next;
    logic [AW-1:0]          best_i_reg, best_i_next, prev_i_reg, prev_i_next;
    logic                   first_reg, first_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    logic [GW-1:0]          pend_grp_reg, pend_grp_next;
    logic [NW-1:0]          pend_cnt_reg, pend_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    logic [cbts_pkg::INDEX_W-1:0] o_idx_reg, o_idx_next;
    logic [cbts_pkg::GROUP_W-1:0] o_grp_reg, o_grp_next;
    logic [NW-1:0]          o_cnt_reg, o_cnt_next;
    logic                   o_none_reg, o_none_next;
    logic                   o_last_reg, o_last_next;

    logic [WW-1:0]          w_cur;
    logic [WW+3:0]          w_x10;
    logic signed [WW:0]     w_s;
    logic signed [BW-1:0]   b_norm, b_last, k_s;
    logic                   out_free, rd_issue, cand_ok;
    logic signed [VW-1:0]   rd_value;
    logic [LW-1:0]          rd_label;
    logic                   push;

    assign w_cur   = weight_reg[g_reg[GI-1:0]];
    assign w_x10   = (WW + 4)'(w_cur) * (WW + 4)'(10);
    assign w_s     = {1'b0, w_cur};
    assign out_free = !m_valid_reg || m_ready;
    assign rd_issue = cmd.scan_step && (addr_reg < sz_reg);
    assign rd_value = ram_rdata[VW-1:0];
    assign rd_label = ram_rdata[LW+VW-1:VW];
    assign k_s      = BW'(k_reg);

    assign ram_we    = load_en && s_operation == cbts_pkg::OP_LOAD_ELEM
                       && 32'(s_element_index) < MAX_ELEMENTS;
    assign ram_waddr = AW'(s_element_index);
    assign ram_wdata = {s_element_label, s_element_value};
    assign ram_re    = rd_issue;
    assign ram_raddr = addr_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (load_en && s_operation == cbts_pkg::OP_LOAD_WEIGHT
            && 32'(s_group_slot) < MAX_GROUPS) begin
            weight_reg[GI'(s_group_slot)] <= s_group_weight;
        end
    end

    // candidate: right group, below the previous pick in (value, index) order
    always_comb begin
        cand_ok = ({1'b0, rd_label} == ((LW + 1)'(g_reg) + (LW + 1)'(1)))
                  && (first_reg || rd_value < prev_v_reg
                      || (rd_value == prev_v_reg && rd_idx_reg < prev_i_reg))
                  && (!found_reg || rd_value >= best_v_reg);
    end

    always_comb begin
        if (w_cur >= thr_reg) begin
            b_norm = BW'(3) + BW'(prod_reg >>> cbts_pkg::Q_SHIFT);
        end else if (w_x10 >= (WW + 4)'(thr_reg)) begin
            b_norm = BW'(1);
        end else begin
            b_norm = '0;
        end
        if (dbl_reg) begin
            b_norm = b_norm <<< 1;
        end
        b_last = (dbl_reg ? (BW'(level_reg) <<< 1) : BW'(level_reg)) - used_reg;
    end

    always_comb begin
        sz_next = sz_reg;   gc_next = gc_reg;   level_next = level_reg;
        dbl_next = dbl_reg; thr_next = thr_reg; g_next = g_reg;
        ncc_next = ncc_reg; nct_next = nct_reg; rem_next = rem_reg;
        prod_next = prod_reg; bud_next = bud_reg; used_next = used_reg;
        k_next = k_reg;     n_next = n_reg;     addr_next = addr_reg;
        rd_vld_next = rd_vld_reg; rd_idx_next = rd_idx_reg;
        found_next = found_reg; best_v_next = best_v_reg; best_i_next = best_i_reg;
        prev_v_next = prev_v_reg; prev_i_next = prev_i_reg; first_next = first_reg;
        pend_vld_next = pend_vld_reg; pend_idx_next = pend_idx_reg;
        pend_grp_next = pend_grp_reg; pend_cnt_next = pend_cnt_reg;
        o_idx_next = o_idx_reg; o_grp_next = o_grp_reg; o_cnt_next = o_cnt_reg;
        o_none_next = o_none_reg; o_last_next = o_last_reg;
        push = 1'b0;

        if (cmd.start_run) begin
            sz_next = (32'(s_element_total) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS)
                                                            : CW'(s_element_total);
            gc_next = (32'(cfg_gcount) > MAX_GROUPS) ? GW'(MAX_GROUPS) : GW'(cfg_gcount);
            level_next = cfg_double ? (cfg_sparsity >> 1) : cfg_sparsity;
            dbl_next = cfg_double;
            thr_next = cfg_thresh;
            g_next = '0;
            ncc_next = '0;
            nct_next = '0;
            n_next = '0;
            pend_vld_next = 1'b0;
        end
        if (cmd.count_step) begin
            if (w_cur >= thr_reg) begin
                ncc_next = ncc_reg + GW'(1);
            end else if (w_x10 >= (WW + 4)'(thr_reg)) begin
                nct_next = nct_reg + GW'(1);
            end
            g_next = g_reg + GW'(1);
        end
        if (cmd.rem_calc) begin
            rem_next = RW'(level_reg) - RW'(ncc_reg) * RW'(3) - RW'(nct_reg);
            g_next = '0;
            used_next = '0;
        end
        if (cmd.bud_mul) begin
            prod_next = PW'(w_s * rem_reg);
        end
        if (cmd.bud_set) begin
            if (g_reg + GW'(1) == gc_reg) begin
                bud_next = b_last;
            end else begin
                bud_next = b_norm;
                used_next = used_reg + b_norm;
            end
            k_next = '0;
            first_next = 1'b1;
        end
        if (cmd.next_group) begin
            g_next = g_reg + GW'(1);
        end
        if (cmd.scan_start) begin
            addr_next = '0;
            found_next = 1'b0;
            rd_vld_next = 1'b0;
        end
        if (cmd.scan_step) begin
            rd_vld_next = rd_issue;
            rd_idx_next = addr_reg[AW-1:0];
            if (rd_issue) begin
                addr_next = addr_reg + CW'(1);
            end
            if (rd_vld_reg && cand_ok) begin
                found_next = 1'b1;
                best_v_next = rd_value;
                best_i_next = rd_idx_reg;
            end
        end
        if (cmd.commit) begin
            if (pend_vld_reg) begin
                push = 1'b1;
                o_idx_next = cbts_pkg::INDEX_W'(pend_idx_reg);
                o_grp_next = cbts_pkg::GROUP_W'(pend_grp_reg);
                o_cnt_next = pend_cnt_reg;
                o_none_next = 1'b0;
                o_last_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_idx_next = best_i_reg;
            pend_grp_next = g_reg;
            pend_cnt_next = n_reg + NW'(1);
            n_next = n_reg + NW'(1);
            k_next = k_reg + KW'(1);
            prev_v_next = best_v_reg;
            prev_i_next = best_i_reg;
            first_next = 1'b0;
        end
        if (cmd.flush) begin
            push = 1'b1;
            o_last_next = 1'b1;
            if (pend_vld_reg) begin
                o_idx_next = cbts_pkg::INDEX_W'(pend_idx_reg);
                o_grp_next = cbts_pkg::GROUP_W'(pend_grp_reg);
                o_cnt_next = pend_cnt_reg;
                o_none_next = 1'b0;
            end else begin
                o_idx_next = '0;
                o_grp_next = '0;
                o_cnt_next = '0;
                o_none_next = 1'b1;
            end
            pend_vld_next = 1'b0;
        end
        m_valid_next = push ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        sz_reg <= sz_next;     gc_reg <= gc_next;     level_reg <= level_next;
        dbl_reg <= dbl_next;   thr_reg <= thr_next;   g_reg <= g_next;
        ncc_reg <= ncc_next;   nct_reg <= nct_next;   rem_reg <= rem_next;
        prod_reg <= prod_next; bud_reg <= bud_next;   used_reg <= used_next;
        k_reg <= k_next;       n_reg <= n_next;       addr_reg <= addr_next;
        rd_idx_reg <= rd_idx_next;
        found_reg <= found_next; best_v_reg <= best_v_next; best_i_reg <= best_i_next;
        prev_v_reg <= prev_v_next; prev_i_reg <= prev_i_next; first_reg <= first_next;
        pend_idx_reg <= pend_idx_next; pend_grp_reg <= pend_grp_next;
        pend_cnt_reg <= pend_cnt_next;
        o_idx_reg <= o_idx_next; o_grp_reg <= o_grp_next; o_cnt_reg <= o_cnt_next;
        o_none_reg <= o_none_next; o_last_reg <= o_last_next;
    end

    always_comb begin
        sts.count_end   = (g_reg == gc_reg);
        sts.group_end   = (g_reg == gc_reg) || (n_reg == NW'(MAX_SELECT));
        sts.pick_more   = (k_s < bud_reg) && (n_reg < NW'(MAX_SELECT));
        sts.scan_done   = (addr_reg >= sz_reg) && !rd_vld_reg;
        sts.pick_ok     = found_reg && (best_v_reg != '0);
        sts.commit_free = !pend_vld_reg || out_free;
        sts.out_free    = out_free;
    end

    assign m_valid          = m_valid_reg;
    assign m_chosen_index   = o_idx_reg;
    assign m_chosen_group   = o_grp_reg;
    assign m_chosen_count   = o_cnt_reg;
    assign m_nothing_chosen = o_none_reg;
    assign m_last_result    = o_last_reg;

endmodule

// ===== rtl/core/component_budget_top_k_select.sv =====
// Loads (element or weight) are accepted only while no run is active.
// A run first classifies each group's weight, then sets up each group's budget in turn; each
// pick attempt makes one full pass over the element store, a group ends when its budget runs
// out or no usable pick is found, and a stalled result sink holds the run at a commit or close.
// Results are held one behind in a pending register so the final one carries last_result.
// Reset (synchronous, aresetn low) clears control state and loads the register defaults;
// element and weight stores are not cleared.
`include "assert_macros.svh"

module component_budget_top_k_select #(
    parameter int MAX_ELEMENTS = cbts_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_GROUPS   = cbts_pkg::MAX_GROUPS_DEF,
    parameter int MAX_SELECT   = cbts_pkg::MAX_SELECT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbts_pkg::PADDR_W-1:0]        paddr,
    input  logic [cbts_pkg::PDATA_W-1:0]        pwdata,
    output logic [cbts_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [cbts_pkg::INDEX_W-1:0]        s_element_index,
    input  logic signed [cbts_pkg::VALUE_W-1:0] s_element_value,
    input  logic [cbts_pkg::LABEL_W-1:0]        s_element_label,
    input  logic [cbts_pkg::SLOT_W-1:0]         s_group_slot,
    input  logic [cbts_pkg::WEIGHT_W-1:0]       s_group_weight,
    input  logic [cbts_pkg::TOTAL_W-1:0]        s_element_total,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cbts_pkg::INDEX_W-1:0]        m_chosen_index,
    output logic [cbts_pkg::GROUP_W-1:0]        m_chosen_group,
    output logic [cbts_pkg::COUNT_W-1:0]        m_chosen_count,
    output logic                                m_nothing_chosen,
    output logic                                m_last_result
);

    logic [cbts_pkg::SPARSITY_W-1:0] sparsity_reg;
    logic [cbts_pkg::GCOUNT_W-1:0]   gcount_reg;
    logic [cbts_pkg::WEIGHT_W-1:0]   thresh_reg;
    logic                            double_reg;
    cbts_pkg::reg_idx_t              reg_sel;
    logic                            cfg_wr;
    cbts_pkg::cmd_t                  cmd;
    cbts_pkg::status_t               sts;

    assign pready  = 1'b1;
    assign reg_sel = cbts_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sparsity_reg <= cbts_pkg::SPARSITY_RST;
            gcount_reg   <= cbts_pkg::GCOUNT_RST;
            thresh_reg   <= cbts_pkg::THRESH_RST;
            double_reg   <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_sel)
                cbts_pkg::REG_SPARSITY: sparsity_reg <= pwdata[cbts_pkg::SPARSITY_W-1:0];
                cbts_pkg::REG_GCOUNT:   gcount_reg   <= pwdata[cbts_pkg::GCOUNT_W-1:0];
                cbts_pkg::REG_THRESH:   thresh_reg   <= pwdata[cbts_pkg::WEIGHT_W-1:0];
                cbts_pkg::REG_DOUBLE:   double_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            cbts_pkg::REG_SPARSITY: prdata = cbts_pkg::PDATA_W'(sparsity_reg);
            cbts_pkg::REG_GCOUNT:   prdata = cbts_pkg::PDATA_W'(gcount_reg);
            cbts_pkg::REG_THRESH:   prdata = cbts_pkg::PDATA_W'(thresh_reg);
            cbts_pkg::REG_DOUBLE:   prdata = cbts_pkg::PDATA_W'(double_reg);
            default:                prdata = '0;
        endcase
    end

    cbts_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    cbts_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_GROUPS   (MAX_GROUPS),
        .MAX_SELECT   (MAX_SELECT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .load_en          (s_valid && s_ready),
        .s_operation      (s_operation),
        .s_element_index  (s_element_index),
        .s_element_value  (s_element_value),
        .s_element_label  (s_element_label),
        .s_group_slot     (s_group_slot),
        .s_group_weight   (s_group_weight),
        .s_element_total  (s_element_total),
        .cfg_sparsity     (sparsity_reg),
        .cfg_gcount       (gcount_reg),
        .cfg_thresh       (thresh_reg),
        .cfg_double       (double_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_chosen_index   (m_chosen_index),
        .m_chosen_group   (m_chosen_group),
        .m_chosen_count   (m_chosen_count),
        .m_nothing_chosen (m_nothing_chosen),
        .m_last_result    (m_last_result)
    );

    `ASSERT_IMPL(a_none_is_last, aclk, aresetn, m_valid && m_nothing_chosen, m_last_result && m_chosen_count == '0, "empty run result must be last with zero count")
    `ASSERT_IMPL(a_count_nonzero, aclk, aresetn, m_valid && !m_nothing_chosen, m_chosen_count != '0 && m_chosen_count <= cbts_pkg::COUNT_W'(MAX_SELECT), "chosen count out of range")
    `ASSERT_IMPL(a_no_load_in_run, aclk, aresetn, m_valid && !m_last_result, !s_ready, "input accepted while run still producing")

endmodule
